[rtl/rar_pkg.sv]
// Package for the rational arithmetic core: opcodes and result field widths.
// No dependencies; used by the front end, the reduction unit and the top level.
`timescale 1ns / 1ps
package rar_pkg;

    localparam int OPCODE_BITS = 3;
    localparam int NUM_BITS    = 34;
    localparam int DEN_BITS    = 32;

    localparam logic [OPCODE_BITS-1:0] OP_REDUCE = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_ADD    = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_SUB    = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_MUL    = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_DIV    = 3'd4;

endpackage

[rtl/rar_front.sv]
// Front end: takes an operation, forms the cross products and the unreduced fraction.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_front #(
    parameter int OPERAND_WIDTH = 16,
    parameter int INT_WIDTH     = 33
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rar_pkg::OPCODE_BITS-1:0]     i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_den,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [INT_WIDTH-1:0]         o_num,
    output logic signed [INT_WIDTH-1:0]         o_den
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam logic signed [OPERAND_WIDTH-1:0] ONE = OPERAND_WIDTH'(1);

    logic [1:0]                          r_state;
    logic [rar_pkg::OPCODE_BITS-1:0]     r_op;
    logic signed [OPERAND_WIDTH-1:0]     r_an, r_ad, r_bn, r_bd;
    logic signed [2*OPERAND_WIDTH-1:0]   r_p0, r_p1, r_p2;
    logic signed [OPERAND_WIDTH-1:0]     n_y0, n_y2;
    logic signed [INT_WIDTH-1:0]         n_p0e, n_p1e;

    // reduce multiplies by one so every opcode shares the same two products
    always_comb begin
        unique case (r_op)
            rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
                n_y0 = r_bd;
                n_y2 = r_bd;
            end
            rar_pkg::OP_MUL: begin
                n_y0 = r_bn;
                n_y2 = r_bd;
            end
            rar_pkg::OP_DIV: begin
                n_y0 = r_bd;
                n_y2 = r_bn;
            end
            default: begin
                n_y0 = ONE;
                n_y2 = ONE;
            end
        endcase
    end

    assign n_p0e = INT_WIDTH'(r_p0);
    assign n_p1e = INT_WIDTH'(r_p1);

    always_comb begin
        unique case (r_op)
            rar_pkg::OP_ADD: o_num = n_p0e + n_p1e;
            rar_pkg::OP_SUB: o_num = n_p0e - n_p1e;
            default:         o_num = n_p0e;
        endcase
    end

    assign o_den   = INT_WIDTH'(r_p2);
    assign o_ready = (r_state == F_IDLE);
    assign o_valid = (r_state == F_PUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: if (i_valid) r_state <= F_MUL;
                F_MUL:  r_state <= F_PUSH;
                F_PUSH: if (i_ready) r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_op <= i_opcode;
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (r_state == F_MUL) begin
            r_p0 <= r_an * n_y0;
            r_p1 <= r_bn * r_ad;
            r_p2 <= r_ad * n_y2;
        end
    end

endmodule

[rtl/rar_fifo.sv]
// Two-entry queue between the front end and the reduction unit.
// No package dependencies.
`timescale 1ns / 1ps
module rar_fifo #(
    parameter int WIDTH = 66
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             n_push, n_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign n_push  = i_valid && o_ready;
    assign n_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wr <= ~r_wr;
            if (n_pop)  r_rd <= ~r_rd;
            if (n_push && !n_pop)      r_cnt <= r_cnt + 2'd1;
            else if (n_pop && !n_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) r_mem[r_wr] <= i_data;
    end

endmodule

[rtl/rar_back.sv]
// Reduction unit: binary GCD of the magnitudes, two restoring dividers, sign restore.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_back #(
    parameter int INT_WIDTH = 33
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [INT_WIDTH-1:0]           i_num,
    input  logic signed [INT_WIDTH-1:0]           i_den,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rar_pkg::NUM_BITS-1:0]   o_res_num,
    output logic signed [rar_pkg::DEN_BITS-1:0]   o_res_den,
    output logic                                  o_status
);

    localparam int CW = $clog2(INT_WIDTH + 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_GCD  = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_SIGN = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]             r_state;
    logic [INT_WIDTH-1:0]   r_u, r_v, r_g, r_qn, r_qd;
    logic [INT_WIDTH:0]     r_rn, r_rd;
    logic [CW-1:0]          r_k, r_cnt;
    logic                   r_nneg, r_dneg;
    logic signed [rar_pkg::NUM_BITS-1:0] r_res_num;
    logic signed [rar_pkg::DEN_BITS-1:0] r_res_den;
    logic                   r_status;

    logic [INT_WIDTH-1:0]   n_mag_n, n_mag_d, n_uv, n_vu;
    logic [INT_WIDTH:0]     n_rn2, n_rd2, n_gx;
    logic                   n_gen, n_ged;
    logic signed [INT_WIDTH-1:0] n_sn, n_sd;
    logic signed [63:0]     n_in_num_x, n_in_den_x, n_sn_x, n_sd_x;

    assign n_mag_n = i_num[INT_WIDTH-1] ? INT_WIDTH'(-i_num) : i_num;
    assign n_mag_d = i_den[INT_WIDTH-1] ? INT_WIDTH'(-i_den) : i_den;
    assign n_uv    = r_u - r_v;
    assign n_vu    = r_v - r_u;

    // one restoring step for each divider, same divisor
    assign n_gx  = {1'b0, r_g};
    assign n_rn2 = {r_rn[INT_WIDTH-1:0], r_qn[INT_WIDTH-1]};
    assign n_rd2 = {r_rd[INT_WIDTH-1:0], r_qd[INT_WIDTH-1]};
    assign n_gen = (n_rn2 >= n_gx);
    assign n_ged = (n_rd2 >= n_gx);

    assign n_sn = r_nneg ? -$signed(r_qn) : $signed(r_qn);
    assign n_sd = r_dneg ? -$signed(r_qd) : $signed(r_qd);

    assign n_in_num_x = 64'(i_num);
    assign n_in_den_x = 64'(i_den);
    assign n_sn_x     = 64'(n_sn);
    assign n_sd_x     = 64'(n_sd);

    assign o_ready   = (r_state == B_IDLE);
    assign o_valid   = (r_state == B_OUT);
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        if (i_den == '0 || i_num == '0) r_state <= B_OUT;
                        else                            r_state <= B_GCD;
                    end
                end
                B_GCD:  if (r_u == r_v) r_state <= B_DIV;
                B_DIV:  if (r_cnt == CW'(1)) r_state <= B_SIGN;
                B_SIGN: r_state <= B_OUT;
                B_OUT:  if (i_ready) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    r_nneg <= i_num[INT_WIDTH-1];
                    r_dneg <= i_den[INT_WIDTH-1];
                    r_u    <= n_mag_n;
                    r_v    <= n_mag_d;
                    r_qn   <= n_mag_n;
                    r_qd   <= n_mag_d;
                    r_k    <= '0;
                    if (i_den == '0) begin
                        r_res_num <= n_in_num_x[rar_pkg::NUM_BITS-1:0];
                        r_res_den <= n_in_den_x[rar_pkg::DEN_BITS-1:0];
                        r_status  <= 1'b1;
                    end else begin
                        r_res_num <= '0;
                        r_res_den <= rar_pkg::DEN_BITS'(1);
                        r_status  <= 1'b0;
                    end
                end
            end
            B_GCD: begin
                priority if (r_u == r_v) begin
                    r_g   <= r_u << r_k;
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= CW'(INT_WIDTH);
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + CW'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= n_uv >> 1;
                end else begin
                    r_v <= n_vu >> 1;
                end
            end
            B_DIV: begin
                r_rn  <= n_gen ? n_rn2 - n_gx : n_rn2;
                r_rd  <= n_ged ? n_rd2 - n_gx : n_rd2;
                r_qn  <= {r_qn[INT_WIDTH-2:0], n_gen};
                r_qd  <= {r_qd[INT_WIDTH-2:0], n_ged};
                r_cnt <= r_cnt - CW'(1);
            end
            B_SIGN: begin
                r_res_num <= n_sn_x[rar_pkg::NUM_BITS-1:0];
                r_res_den <= n_sd_x[rar_pkg::DEN_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/rational_arith_reduce_core.sv]
// Rational arithmetic core: front end, two-entry queue and reduction unit.
// The front end holds one operation at a time (idle, multiply, push) and takes a new
// transfer only when idle; reduction runs the binary GCD loop, the bit-serial dividers
// and the sign restore, while zero cases go straight to the result.
// Synchronous active-low reset empties the queue and returns both ends to idle.
`timescale 1ns / 1ps
module rational_arith_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [rar_pkg::OPCODE_BITS-1:0]       i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_den,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rar_pkg::NUM_BITS-1:0]   o_res_num,
    output logic signed [rar_pkg::DEN_BITS-1:0]   o_res_den,
    output logic                                  o_status
);

    // intermediates wrap at 64 bits, as the arithmetic is defined
    localparam int IW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;

    logic                 f_valid, f_ready, q_valid, q_ready;
    logic signed [IW-1:0] f_num, f_den, q_num, q_den;
    logic [2*IW-1:0]      q_data;
    logic [2:0]           r_pending;

    rar_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .INT_WIDTH     (IW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .i_a_num  (i_a_num),
        .i_a_den  (i_a_den),
        .i_b_num  (i_b_num),
        .i_b_den  (i_b_den),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_num    (f_num),
        .o_den    (f_den)
    );

    rar_fifo #(
        .WIDTH (2 * IW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_num, f_den}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign q_num = q_data[2*IW-1:IW];
    assign q_den = q_data[IW-1:0];

    rar_back #(
        .INT_WIDTH (IW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_num     (q_num),
        .i_den     (q_den),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_status  (o_status)
    );

    // items in flight: front end, two queue slots and the reduction unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= r_pending + 3'((i_valid && o_ready) ? 1 : 0)
                                   - 3'((o_valid && i_ready) ? 1 : 0);
        end
    end

    a_status_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_res_den == '0)
        else $error("zero-denominator status with nonzero denominator");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 3'd0)
        else $error("result presented with no item in flight");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd4)
        else $error("more items in flight than the datapath holds");

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && !q_valid && !o_valid |=> !(f_valid && !f_ready))
        else $error("queue refused a transfer while empty");

endmodule
